// ===== rtl/fct_pkg.sv =====
// Shared types, constants and helpers for the MAC pair flow counter table.
// No dependencies; every other file of the block but fct_ram imports this package.
`timescale 1ns / 1ps

package fct_pkg;

    // Table size default and field widths
    localparam int FCT_TABLE_DEPTH = 64;
    localparam int MAC_W           = 48;
    localparam int CNT_W           = 32;
    localparam int TS_W            = 32;
    localparam int LEN_W           = 16;
    localparam int SIZE_W          = LEN_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int INTERVAL_W = 16;
    localparam int OVERHEAD_W = 8;

    localparam logic [INTERVAL_W-1:0] DUMP_INTERVAL_RST = 16'd10;
    localparam logic [OVERHEAD_W-1:0] OVERHEAD_RST      = 8'd26;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DUMP_INTERVAL = 1'b0,
        REG_OVERHEAD      = 1'b1
    } fct_reg_idx_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] dump_interval;
        logic [OVERHEAD_W-1:0] overhead;
    } fct_cfg_t;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [MAC_W-1:0] src;
        logic [MAC_W-1:0] dst;
        logic [CNT_W-1:0] bytes;
        logic [CNT_W-1:0] packets;
    } fct_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DUMP_SCAN,
        ST_DUMP_LOAD,
        ST_MATCH
    } fct_state_t;

    // Controller status seen by the top level
    typedef struct packed {
        logic busy;
        logic dumping;
    } fct_stat_t;

    // Saturating 32-bit add
    function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// ===== rtl/fct_in_if.sv =====
// Input channel of the flow counter table: one frame descriptor per item.
// Depends on fct_pkg for the field widths.
`timescale 1ns / 1ps

interface fct_in_if
    import fct_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [TS_W-1:0]  timestamp_seconds;
    logic [LEN_W-1:0] frame_length;
    logic [MAC_W-1:0] source_mac;
    logic [MAC_W-1:0] destination_mac;

    modport source (
        output valid, timestamp_seconds, frame_length, source_mac, destination_mac,
        input  ready
    );

    modport sink (
        input  valid, timestamp_seconds, frame_length, source_mac, destination_mac,
        output ready
    );
endinterface

// ===== rtl/fct_out_if.sv =====
// Output channel of the flow counter table: one dumped flow entry per item.
// Depends on fct_pkg for the field widths.
`timescale 1ns / 1ps

interface fct_out_if
    import fct_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [MAC_W-1:0] flow_source;
    logic [MAC_W-1:0] flow_destination;
    logic [CNT_W-1:0] flow_bytes;
    logic [CNT_W-1:0] flow_packets;
    logic             last_of_dump;

    modport source (
        output valid, flow_source, flow_destination, flow_bytes, flow_packets,
               last_of_dump,
        input  ready
    );

    modport sink (
        input  valid, flow_source, flow_destination, flow_bytes, flow_packets,
               last_of_dump,
        output ready
    );
endinterface

// ===== rtl/fct_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds its value between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fct_cfg.sv =====
// Configuration registers of the flow counter table (dump interval, overhead).
// Depends on fct_pkg.
`timescale 1ns / 1ps

module fct_cfg
    import fct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output fct_cfg_t              cfg
);

    fct_cfg_t cfg_reg;
    fct_cfg_t cfg_next;

    // Register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (fct_reg_idx_t'(cfg_index))
                REG_DUMP_INTERVAL: cfg_next.dump_interval = cfg_data[INTERVAL_W-1:0];
                REG_OVERHEAD:      cfg_next.overhead      = cfg_data[OVERHEAD_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dump_interval <= DUMP_INTERVAL_RST;
            cfg_reg.overhead      <= OVERHEAD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/fct_ctrl.sv =====
// Sequencer of the flow counter table: dump walk, match scan, update/allocate,
// in-use flags and the output register. Depends on fct_pkg, fct_in_if, fct_out_if.
`timescale 1ns / 1ps

module fct_ctrl
    import fct_pkg::*;
#(
    parameter int TABLE_DEPTH = FCT_TABLE_DEPTH,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    fct_in_if.sink           in_ch,
    fct_out_if.source        out_ch,
    input  fct_cfg_t         cfg,
    output logic             ram_re,
    output logic [IDX_W-1:0] ram_raddr,
    input  fct_entry_t       ram_rdata,
    output logic             ram_we,
    output logic [IDX_W-1:0] ram_waddr,
    output fct_entry_t       ram_wdata,
    output fct_stat_t        stat
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Control state
    fct_state_t             state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   issuing_reg, issuing_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [TABLE_DEPTH-1:0] in_use_reg, in_use_next;
    logic [TS_W-1:0]        last_dump_reg, last_dump_next;
    logic                   out_valid_reg, out_valid_next;

    // Item and output payload
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [MAC_W-1:0]  src_reg, src_next;
    logic [MAC_W-1:0]  dst_reg, dst_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    fct_entry_t        out_entry_reg, out_entry_next;
    logic              out_last_reg, out_last_next;

    logic                   dump_due;
    logic                   advance;
    logic                   hit;
    logic                   out_free;
    logic [TABLE_DEPTH-1:0] rest_in_use;

    assign out_free = !out_valid_reg || out_ch.ready;

    // Dump is due when last dump time plus interval, without wrap, is below the stamp
    assign dump_due = ({1'b0, last_dump_reg} + {{(TS_W + 1 - INTERVAL_W){1'b0}},
                      cfg.dump_interval}) < {1'b0, in_ch.timestamp_seconds};

    // Key match on the entry read in the previous cycle
    assign hit = cmp_vld_reg && in_use_reg[cmp_idx_reg]
              && (ram_rdata.src == src_reg) && (ram_rdata.dst == dst_reg);

    // Next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        issuing_next    = issuing_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        in_use_next     = in_use_reg;
        last_dump_next  = last_dump_reg;
        out_valid_next  = out_valid_reg;
        ts_next         = ts_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        size_next       = size_reg;
        out_entry_next  = out_entry_reg;
        out_last_next   = out_last_reg;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg;
        ram_we          = 1'b0;
        ram_waddr       = cmp_idx_reg;
        ram_wdata       = ram_rdata;
        advance         = 1'b0;
        rest_in_use     = in_use_reg;
        rest_in_use[idx_reg] = 1'b0;

        // Output register drains independently
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    ts_next   = in_ch.timestamp_seconds;
                    src_next  = in_ch.source_mac;
                    dst_next  = in_ch.destination_mac;
                    size_next = {1'b0, in_ch.frame_length} + SIZE_W'(cfg.overhead);
                    idx_next  = '0;
                    free_found_next = 1'b0;
                    if (dump_due)
                    begin
                        state_next = ST_DUMP_SCAN;
                    end
                    else
                    begin
                        state_next   = ST_MATCH;
                        issuing_next = 1'b1;
                    end
                end
            end

            ST_DUMP_SCAN:
            begin
                if (in_use_reg[idx_reg])
                begin
                    if (out_free)
                    begin
                        ram_re     = 1'b1;
                        state_next = ST_DUMP_LOAD;
                    end
                end
                else
                begin
                    advance = 1'b1;
                end
            end

            ST_DUMP_LOAD:
            begin
                // Emit the entry and free it; last when nothing else is in use
                out_entry_next       = ram_rdata;
                out_last_next        = ~|rest_in_use;
                out_valid_next       = 1'b1;
                in_use_next[idx_reg] = 1'b0;
                state_next           = ST_DUMP_SCAN;
                advance              = 1'b1;
            end

            ST_MATCH:
            begin
                // Issue side: one read per cycle, note the lowest free entry
                ram_re       = issuing_reg;
                cmp_vld_next = issuing_reg;
                if (issuing_reg)
                begin
                    if (!free_found_reg && !in_use_reg[idx_reg])
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end

                // Compare side
                if (hit)
                begin
                    ram_we            = 1'b1;
                    ram_waddr         = cmp_idx_reg;
                    ram_wdata.src     = src_reg;
                    ram_wdata.dst     = dst_reg;
                    ram_wdata.bytes   = sat_add32(ram_rdata.bytes, CNT_W'(size_reg));
                    ram_wdata.packets = sat_add32(ram_rdata.packets, CNT_W'(1));
                    cmp_vld_next      = 1'b0;
                    issuing_next      = 1'b0;
                    state_next        = ST_IDLE;
                end
                else if (cmp_vld_reg && (cmp_idx_reg == LAST_IDX))
                begin
                    // No match: take the lowest free entry, or drop when full
                    if (free_found_reg)
                    begin
                        ram_we            = 1'b1;
                        ram_waddr         = free_idx_reg;
                        ram_wdata.src     = src_reg;
                        ram_wdata.dst     = dst_reg;
                        ram_wdata.bytes   = CNT_W'(size_reg);
                        ram_wdata.packets = CNT_W'(1);
                        in_use_next[free_idx_reg] = (size_reg != '0);
                    end
                    cmp_vld_next = 1'b0;
                    issuing_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Dump walk step; the end of the walk starts the match scan
        if (advance)
        begin
            if (idx_reg == LAST_IDX)
            begin
                last_dump_next = ts_reg;
                idx_next       = '0;
                issuing_next   = 1'b1;
                state_next     = ST_MATCH;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            issuing_reg    <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            in_use_reg     <= '0;
            last_dump_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            issuing_reg    <= issuing_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            in_use_reg     <= in_use_next;
            last_dump_reg  <= last_dump_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ts_reg        <= ts_next;
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        size_reg      <= size_next;
        out_entry_reg <= out_entry_next;
        out_last_reg  <= out_last_next;
    end

    // Ports
    assign in_ch.ready             = (state_reg == ST_IDLE);
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.flow_source      = out_entry_reg.src;
    assign out_ch.flow_destination = out_entry_reg.dst;
    assign out_ch.flow_bytes       = out_entry_reg.bytes;
    assign out_ch.flow_packets     = out_entry_reg.packets;
    assign out_ch.last_of_dump     = out_last_reg;

    assign stat.busy    = (state_reg != ST_IDLE);
    assign stat.dumping = (state_reg == ST_DUMP_SCAN) || (state_reg == ST_DUMP_LOAD);

endmodule

// ===== rtl/mac_pair_flow_counter_table.sv =====
// Flow counter table: without a dump, an item that misses reads every entry of the table
// before the next accept, and a hit on entry k ends the scan there (one read per entry
// through the table RAM port, the compare in the cycle after the read).
// A due dump first walks every index, with a load step per emitted entry and waits on
// output stalls; a dumped entry is read in ST_DUMP_SCAN and registered out in ST_DUMP_LOAD.
// Reset (async, active low) frees every entry, zeroes the last dump time and loads
// interval 10 s and overhead 26 bytes; no clearing pass, ready right after reset.
`timescale 1ns / 1ps

module mac_pair_flow_counter_table
    import fct_pkg::*;
#(
    parameter int TABLE_DEPTH = FCT_TABLE_DEPTH,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    fct_in_if.sink                in_ch,
    fct_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    fct_cfg_t         cfg;
    fct_stat_t        stat;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    fct_entry_t       ram_rdata;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    fct_entry_t       ram_wdata;

    // Configuration registers
    fct_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Entry storage: addresses, byte and packet counters
    fct_ram #(
        .WIDTH ($bits(fct_entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer
    fct_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg       (cfg),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .stat      (stat)
    );

    // One item in flight: an accepted item blocks the next edge
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input accepted while an item is in work");

    // No input accepted while the table is being worked on
    a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> !in_ch.ready)
        else $error("ready while busy");

    // A new output item is only produced by a dump walk
    a_out_from_dump: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !$past(out_ch.valid) |-> $past(stat.dumping))
        else $error("output item outside a dump");

    // Only in-use entries are dumped, so a dumped entry never has zero bytes
    a_out_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.flow_bytes != '0))
        else $error("dumped entry with zero bytes");

endmodule
